// ----- rtl/core/mpc_pkg.sv -----
// Package for the matrix property checker: shared constants, register codes
// and the element position word passed from the index stage to the checker.
// No dependencies.
package mpc_pkg;

  localparam int DEF_MAX_ORDER    = 32;
  localparam int DEF_ELEMENT_BITS = 32;

  localparam int ORDER_REG_BITS = 6;
  localparam int DIAG_SUM_BITS  = 32;
  localparam int APB_ADDR_BITS  = 3;
  localparam int APB_DATA_BITS  = 32;

  // Register index codes (paddr[2])
  localparam logic REG_MATRIX_ORDER = 1'b0;

  localparam logic [ORDER_REG_BITS-1:0] ORDER_RESET = ORDER_REG_BITS'(1);

  // Where the current element sits in the matrix
  typedef struct packed {
    logic is_upper;  // above the main diagonal
    logic is_lower;  // below the main diagonal
    logic on_diag;   // on the main or the anti diagonal
    logic is_last;   // final element of the matrix
  } pos_t;

endpackage

// ----- rtl/core/matrix_property_checker_unit.sv -----
// Top level of the matrix property checker: row/column sequencing, upper
// store addressing and wiring of the register, store and check blocks.
// Depends on mpc_pkg, mpc_cfg_regs, mpc_store and mpc_accum.
//
// Usage:
//   Stream the n*n elements of a square matrix on the element channel
//   (element_valid / element_stall / element_value), row-major order.
//   A word is taken at each rising edge with element_valid high and
//   element_stall low. After the last element of a matrix one result word
//   appears on the result channel: is_symmetric, is_diagonal,
//   is_lower_triangular and diagonal_sum (main plus anti diagonal, center
//   counted once, wrapping). No result is produced for other elements.
//   Throughput: one element per clock while element_stall is low, set by
//   the single-ported read of the upper store plus one compare/add stage.
//   Result path: the last element and its mirror read are registered,
//   then checked into the result register.
//   Stall: a waiting result does not block the input; element_stall rises
//   only while the final element of the next matrix needs the result
//   register and result_stall is high.
//   Reset: order 1, indices, flags and sum cleared, no result pending.
//   The store needs no clearing pass: each mirror is written before read.
//   Writing matrix_order (byte address 0) restarts the matrix and clamps
//   its order to 1..MAX_ORDER; write it only while the block is idle.
module matrix_property_checker_unit import mpc_pkg::*; #(
  parameter int MAX_ORDER    = DEF_MAX_ORDER,
  parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [APB_ADDR_BITS-1:0]        paddr,
  input  logic [APB_DATA_BITS-1:0]        pwdata,
  output logic [APB_DATA_BITS-1:0]        prdata,
  output logic                            pready,
  input  logic                            element_valid,
  output logic                            element_stall,
  input  logic signed [ELEMENT_BITS-1:0]  element_value,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            is_symmetric,
  output logic                            is_diagonal,
  output logic                            is_lower_triangular,
  output logic signed [DIAG_SUM_BITS-1:0] diagonal_sum
);

  localparam int IDX_BITS  = $clog2(MAX_ORDER);
  localparam int ADDR_BITS = 2 * IDX_BITS;

  logic [IDX_BITS-1:0]     last_idx;
  logic                    restart;
  logic [IDX_BITS-1:0]     row;
  logic [IDX_BITS-1:0]     col;
  logic [IDX_BITS:0]       idx_sum;
  logic                    accept;
  logic                    hold;
  pos_t                    pos;
  logic [ELEMENT_BITS-1:0] value;
  logic [ELEMENT_BITS-1:0] mirror;

  assign accept        = element_valid && !hold;
  assign element_stall = hold;
  assign value         = element_value;

  mpc_cfg_regs #(
    .MAX_ORDER (MAX_ORDER),
    .IDX_BITS  (IDX_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .last_idx (last_idx),
    .restart  (restart)
  );

  // Classify the element at (row, col)
  assign idx_sum = {1'b0, row} + {1'b0, col};

  always_comb begin
    pos.is_upper = (col > row);
    pos.is_lower = (col < row);
    pos.on_diag  = (col == row) || (idx_sum == {1'b0, last_idx});
    pos.is_last  = (row == last_idx) && (col == last_idx);
  end

  // Advance through the matrix in row-major order
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row <= '0;
      col <= '0;
    end else if (accept) begin
      if (pos.is_last) begin
        row <= '0;
        col <= '0;
      end else if (col == last_idx) begin
        row <= row + IDX_BITS'(1);
        col <= '0;
      end else begin
        col <= col + IDX_BITS'(1);
      end
    end
  end

  // Upper elements go in at (row, col); lower elements read their mirror
  // at (col, row). The mirror is always written before it is read.
  mpc_store #(
    .ADDR_BITS    (ADDR_BITS),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_store (
    .clk   (clk),
    .we    (accept && pos.is_upper),
    .waddr ({row, col}),
    .wdata (value),
    .re    (accept && pos.is_lower),
    .raddr ({col, row}),
    .rdata (mirror)
  );

  mpc_accum #(
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_accum (
    .clk                 (clk),
    .rst                 (rst),
    .restart             (restart),
    .accept              (accept),
    .pos                 (pos),
    .value               (value),
    .mirror              (mirror),
    .hold                (hold),
    .result_valid        (result_valid),
    .result_stall        (result_stall),
    .is_symmetric        (is_symmetric),
    .is_diagonal         (is_diagonal),
    .is_lower_triangular (is_lower_triangular),
    .diagonal_sum        (diagonal_sum)
  );

`ifndef SYNTH
  // A new result comes from an earlier taken element
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(accept, 2))
    else $error("result appeared without a preceding element");

  // Indices never leave the configured matrix
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (row <= last_idx) && (col <= last_idx))
    else $error("row or column index beyond matrix order");

  // Input back-pressure only comes from a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    element_stall |-> (result_valid && result_stall))
    else $error("element stall without a blocked result");

  // A diagonal matrix is always lower triangular
  a_flag_consistency: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!is_diagonal || is_lower_triangular))
    else $error("diagonal flag set without lower-triangular flag");
`endif

endmodule

// ----- rtl/core/mpc_cfg_regs.sv -----
// APB register block of the matrix property checker: holds the order register
// and the derived last index. Depends on mpc_pkg.
module mpc_cfg_regs import mpc_pkg::*; #(
  parameter int MAX_ORDER = DEF_MAX_ORDER,
  parameter int IDX_BITS  = $clog2(MAX_ORDER)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_BITS-1:0]  paddr,
  input  logic [APB_DATA_BITS-1:0]  pwdata,
  output logic [APB_DATA_BITS-1:0]  prdata,
  output logic                      pready,
  output logic [IDX_BITS-1:0]       last_idx,
  output logic                      restart
);

  localparam logic [ORDER_REG_BITS:0] MAX_ORD_W = (ORDER_REG_BITS+1)'(MAX_ORDER);

  logic [ORDER_REG_BITS-1:0] matrix_order;
  logic [ORDER_REG_BITS-1:0] wr_order;
  logic [IDX_BITS-1:0]       last_idx_next;
  logic                      wr_en;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite && (paddr[2] == REG_MATRIX_ORDER);
  assign restart  = wr_en;
  assign wr_order = pwdata[ORDER_REG_BITS-1:0];

  // Clamp the order to 1..MAX_ORDER and keep n-1
  always_comb begin
    if (wr_order == '0) begin
      last_idx_next = '0;
    end else if ({1'b0, wr_order} > MAX_ORD_W) begin
      last_idx_next = IDX_BITS'(MAX_ORDER - 1);
    end else begin
      last_idx_next = IDX_BITS'(wr_order - ORDER_REG_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_order <= ORDER_RESET;
      last_idx     <= '0;
    end else if (wr_en) begin
      matrix_order <= wr_order;
      last_idx     <= last_idx_next;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MATRIX_ORDER) begin
      prdata = APB_DATA_BITS'(matrix_order);
    end
  end

endmodule

// ----- rtl/core/mpc_store.sv -----
// Upper-triangle element memory of the matrix property checker: one write
// port, one read port with registered read data. Depends on mpc_pkg.
module mpc_store import mpc_pkg::*; #(
  parameter int ADDR_BITS    = 10,
  parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [ADDR_BITS-1:0]    waddr,
  input  logic [ELEMENT_BITS-1:0] wdata,
  input  logic                    re,
  input  logic [ADDR_BITS-1:0]    raddr,
  output logic [ELEMENT_BITS-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [ELEMENT_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/mpc_accum.sv -----
// Check stage of the matrix property checker: running flags, diagonal sum and
// the result register. Depends on mpc_pkg.
module mpc_accum import mpc_pkg::*; #(
  parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            restart,
  input  logic                            accept,
  input  pos_t                            pos,
  input  logic [ELEMENT_BITS-1:0]         value,
  input  logic [ELEMENT_BITS-1:0]         mirror,
  output logic                            hold,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            is_symmetric,
  output logic                            is_diagonal,
  output logic                            is_lower_triangular,
  output logic signed [DIAG_SUM_BITS-1:0] diagonal_sum
);

  logic                    s1_valid;
  pos_t                    s1_pos;
  logic [ELEMENT_BITS-1:0] s1_value;
  logic                    advance;
  logic                    sym;
  logic                    upper_zero;
  logic                    lower_zero;
  logic [ELEMENT_BITS-1:0] sum;
  logic                    sym_next;
  logic                    upper_zero_next;
  logic                    lower_zero_next;
  logic [ELEMENT_BITS-1:0] sum_next;
  logic                    nonzero;

  // Only the final element can be blocked, by an untaken result
  assign hold    = s1_valid && s1_pos.is_last && result_valid && result_stall;
  assign advance = s1_valid && !hold;
  assign nonzero = (s1_value != '0);

  always_comb begin
    sym_next        = sym && !(s1_pos.is_lower && (s1_value != mirror));
    upper_zero_next = upper_zero && !(s1_pos.is_upper && nonzero);
    lower_zero_next = lower_zero && !(s1_pos.is_lower && nonzero);
    sum_next        = s1_pos.on_diag ? sum + s1_value : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos   <= pos;
      s1_value <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      sym        <= 1'b1;
      upper_zero <= 1'b1;
      lower_zero <= 1'b1;
      sum        <= '0;
    end else if (advance) begin
      if (s1_pos.is_last) begin
        sym        <= 1'b1;
        upper_zero <= 1'b1;
        lower_zero <= 1'b1;
        sum        <= '0;
      end else begin
        sym        <= sym_next;
        upper_zero <= upper_zero_next;
        lower_zero <= lower_zero_next;
        sum        <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && s1_pos.is_last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_pos.is_last) begin
      is_symmetric        <= sym_next;
      is_diagonal         <= upper_zero_next && lower_zero_next;
      is_lower_triangular <= upper_zero_next;
      diagonal_sum        <= DIAG_SUM_BITS'(sum_next);
    end
  end

endmodule

// ----- tb/matrix_property_checker_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for matrix_property_checker_unit: streams square matrices
// through the element channel and checks each property word against a local model.
// Depends on mpc_pkg and the matrix_property_checker_unit RTL.
module matrix_property_checker_unit_test import mpc_pkg::*;;

  localparam int ORDER_CAP = DEF_MAX_ORDER;
  localparam int VALUE_BITS = DEF_ELEMENT_BITS;
  localparam logic [APB_ADDR_BITS-1:0] ORDER_ADDR = {REG_MATRIX_ORDER, 2'b00};

  // One property word: what the block reports after the last element of a matrix
  typedef struct packed {
    logic                     sym;
    logic                     diag;
    logic                     lower;
    logic [DIAG_SUM_BITS-1:0] sum;
  } property_word_t;

  // One directed row: optional order write before it, the element, and the
  // property word it must close with when that can be read off by hand
  typedef struct packed {
    logic                     set_order;
    logic [ORDER_REG_BITS-1:0] order;
    logic [VALUE_BITS-1:0]    value;
    logic                     typed;
    logic                     sym;
    logic                     diag;
    logic                     lower;
    logic [DIAG_SUM_BITS-1:0] sum;
  } step_row_t;

  // Shapes of generated matrices; most are well formed so the flags stay set
  // until late in the matrix
  typedef enum int {
    SHAPE_RANDOM,
    SHAPE_SYMMETRIC,
    SHAPE_DIAGONAL,
    SHAPE_LOWER,
    SHAPE_UPPER,
    SHAPE_ZERO,
    SHAPE_NEAR_SYMMETRIC
  } shape_e;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic pready;
  logic element_valid;
  logic element_stall;
  logic signed [VALUE_BITS-1:0] element_value;
  logic result_valid;
  logic result_stall = 1'b0;
  logic is_symmetric, is_diagonal, is_lower_triangular;
  logic signed [DIAG_SUM_BITS-1:0] diagonal_sum;

  matrix_property_checker_unit uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .element_valid(element_valid), .element_stall(element_stall),
    .element_value(element_value),
    .result_valid(result_valid), .result_stall(result_stall),
    .is_symmetric(is_symmetric), .is_diagonal(is_diagonal),
    .is_lower_triangular(is_lower_triangular), .diagonal_sum(diagonal_sum)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state: order register, mirror store of the upper part, position
  // and the running flags and sum of the matrix in flight
  logic [ORDER_REG_BITS-1:0] order_setting;
  logic [VALUE_BITS-1:0] mirror_store [0:ORDER_CAP*ORDER_CAP-1];
  int unsigned at_row, at_col;
  logic still_symmetric, upper_clear, lower_clear;
  logic [DIAG_SUM_BITS-1:0] diag_total;

  property_word_t pending_properties [$];
  logic [VALUE_BITS-1:0] matrix_buf [0:ORDER_CAP-1][0:ORDER_CAP-1];

  int unsigned element_count = 0;
  int unsigned failures = 0;
  bit quiet_stretch = 1'b0;   // no idling on either side while set
  bit hold_request = 1'b0;    // ask the receiver for one long hold-off
  bit hold_done = 1'b0;
  int unsigned hold_left = 0;

  // Directed rows: extremes of the element, order zero and saturation, the
  // wrap of the diagonal sum, the center counted once, and a partly streamed
  // matrix dropped by an order write
  step_row_t directed_rows [0:23] = '{
    // order 1 straight out of reset
    '{1'b0, 6'd0,  32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b1, 32'h0000_0000},
    '{1'b0, 6'd0,  32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{1'b0, 6'd0,  32'h8000_0000, 1'b1, 1'b1, 1'b1, 1'b1, 32'h8000_0000},
    // order zero behaves as order one
    '{1'b1, 6'd0,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF},
    // order 2, symmetric with nonzero off-diagonal; every element is on a diagonal
    '{1'b1, 6'd2,  32'd1,         1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 6'd0,  32'd2,         1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 6'd0,  32'd2,         1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 6'd0,  32'd3,         1'b1, 1'b1, 1'b0, 1'b0, 32'd8},
    // order 2, upper part zero, lower part not: lower triangular only
    '{1'b0, 6'd0,  32'd5,         1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 6'd0,  32'd0,         1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 6'd0,  32'd7,         1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 6'd0,  32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b1, 32'h8000_000C},
    // order 3 diagonal matrix; center once, sum wraps
    '{1'b1, 6'd3,  32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 6'd0,  32'd0,         1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 6'd0,  32'd0,         1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 6'd0,  32'd0,         1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 6'd0,  32'd1,         1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 6'd0,  32'd0,         1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 6'd0,  32'd0,         1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 6'd0,  32'd0,         1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 6'd0,  32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF},
    // top of the register saturates to the largest order; start, then drop
    '{1'b1, 6'd63, 32'hDEAD_BEEF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 6'd0,  32'h0000_0001, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b1, 6'd1,  32'h1234_5678, 1'b1, 1'b1, 1'b1, 1'b1, 32'h1234_5678}
  };

  function automatic int unsigned active_order();
    if (order_setting == '0) return 1;
    if (order_setting > ORDER_CAP) return ORDER_CAP;
    return 32'(order_setting);
  endfunction

  task automatic clear_matrix();
    at_row = 0;
    at_col = 0;
    still_symmetric = 1'b1;
    upper_clear = 1'b1;
    lower_clear = 1'b1;
    diag_total = '0;
  endtask

  // Advance the model by one element; closing the matrix yields a property word
  task automatic predict_properties(input logic [VALUE_BITS-1:0] v, output bit got,
                                    output property_word_t word);
    int unsigned n, r, c;
    n = active_order();
    r = at_row;
    c = at_col;
    got = 1'b0;
    word = '0;
    if (c > r) begin
      mirror_store[r*ORDER_CAP + c] = v;
      if (v != '0) upper_clear = 1'b0;
    end else if (c < r) begin
      if (v != mirror_store[c*ORDER_CAP + r]) still_symmetric = 1'b0;
      if (v != '0) lower_clear = 1'b0;
    end
    // the center sits on both diagonals but is added once
    if (c == r || c == n - 1 - r) diag_total = diag_total + v;
    if (r == n - 1 && c == n - 1) begin
      got = 1'b1;
      word.sym = still_symmetric;
      word.diag = upper_clear && lower_clear;
      word.lower = upper_clear;
      word.sum = diag_total;
      clear_matrix();
    end else if (c == n - 1) begin
      at_col = 0;
      at_row = r + 1;
    end else begin
      at_col = c + 1;
    end
  endtask

  // Mostly zeros, extremes and small signed values, so the flags and the
  // wrap of the sum get exercised, with full random words for bit toggling
  function automatic logic [VALUE_BITS-1:0] pick_element();
    case ($urandom_range(0, 9))
      0, 1: return '0;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'hFFFF_FFFF;
      5: return 32'($urandom_range(0, 15)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  // Offer one element word and hold it until taken; idle first at random
  task automatic send_element(input logic [VALUE_BITS-1:0] v);
    if (!quiet_stretch && $urandom_range(0, 99) < 4) begin
      element_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    element_valid <= 1'b1;
    element_value <= v;
    do @(posedge clk); while (element_stall);
    element_count++;
  endtask

  // Drain all outstanding words, let the pipe settle, then write the order
  // register through a setup and an access cycle
  task automatic write_order(input logic [ORDER_REG_BITS-1:0] v);
    element_valid <= 1'b0;
    while (pending_properties.size() != 0) @(posedge clk);
    // the last element of a dropped matrix may still be in the pipe
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ORDER_ADDR;
    pwdata <= APB_DATA_BITS'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    order_setting = v;
    clear_matrix();
  endtask

  // Build a matrix of a random shape and stream its first count elements;
  // a count short of n*n leaves a partly streamed matrix behind
  task automatic stream_matrix(input int unsigned n, input int unsigned count);
    shape_e shape;
    int unsigned r, c, fr, fc, i;
    bit got;
    property_word_t word;
    shape = shape_e'($urandom_range(0, 6));
    for (r = 0; r < n; r++) begin
      for (c = 0; c < n; c++) begin
        matrix_buf[r][c] = pick_element();
        case (shape)
          SHAPE_SYMMETRIC, SHAPE_NEAR_SYMMETRIC: begin
            if (c < r) matrix_buf[r][c] = matrix_buf[c][r];
          end
          SHAPE_DIAGONAL: begin
            if (c != r) matrix_buf[r][c] = '0;
          end
          SHAPE_LOWER: begin
            if (c > r) matrix_buf[r][c] = '0;
          end
          SHAPE_UPPER: begin
            if (c < r) matrix_buf[r][c] = '0;
          end
          SHAPE_ZERO: begin
            matrix_buf[r][c] = '0;
          end
          default: ;
        endcase
      end
    end
    // break symmetry by a single flipped bit below the diagonal
    if (shape == SHAPE_NEAR_SYMMETRIC && n > 1) begin
      fr = $urandom_range(1, n - 1);
      fc = $urandom_range(0, fr - 1);
      matrix_buf[fr][fc] ^= VALUE_BITS'(1) << $urandom_range(0, VALUE_BITS - 1);
    end
    for (i = 0; i < count; i++) begin
      predict_properties(matrix_buf[i / n][i % n], got, word);
      if (got) pending_properties.push_back(word);
      send_element(matrix_buf[i / n][i % n]);
    end
  endtask

  // Compare one taken property word with the oldest expectation
  function automatic void check_properties();
    property_word_t want;
    if (pending_properties.size() == 0) begin
      $error("property word with no matrix outstanding: sym %0d diag %0d lower %0d sum %h",
             is_symmetric, is_diagonal, is_lower_triangular, diagonal_sum);
      failures++;
      return;
    end
    want = pending_properties.pop_front();
    if (is_symmetric !== want.sym) begin
      $error("is_symmetric: expected %0d, got %0d", want.sym, is_symmetric);
      failures++;
    end
    if (is_diagonal !== want.diag) begin
      $error("is_diagonal: expected %0d, got %0d", want.diag, is_diagonal);
      failures++;
    end
    if (is_lower_triangular !== want.lower) begin
      $error("is_lower_triangular: expected %0d, got %0d", want.lower, is_lower_triangular);
      failures++;
    end
    if (diagonal_sum !== want.sum) begin
      $error("diagonal_sum: expected %h, got %h", want.sum, diagonal_sum);
      failures++;
    end
  endfunction

  // Receiver: take and check words, stall at random, and once hold off long
  // enough that the result register stays full and the input backs up
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) check_properties();
      if (hold_request && !hold_done) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !quiet_stretch && ($urandom_range(0, 99) < 8);
      end
    end
  end

  // Stimulus: reset, directed rows, then random phases of whole matrices
  initial begin
    int unsigned idx, phase, n, mats;
    logic [ORDER_REG_BITS-1:0] raw;
    bit got, big_done;
    property_word_t word;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    element_valid = 1'b0;
    element_value = '0;
    order_setting = ORDER_RESET;
    clear_matrix();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed rows; a typed row closes a matrix whose word is known by hand
    for (idx = 0; idx < 24; idx++) begin
      if (directed_rows[idx].set_order) write_order(directed_rows[idx].order);
      predict_properties(directed_rows[idx].value, got, word);
      if (got) begin
        if (directed_rows[idx].typed) begin
          word.sym = directed_rows[idx].sym;
          word.diag = directed_rows[idx].diag;
          word.lower = directed_rows[idx].lower;
          word.sum = directed_rows[idx].sum;
        end
        pending_properties.push_back(word);
      end
      send_element(directed_rows[idx].value);
    end

    // Random phases: mostly small orders, one full matrix at the largest
    // order, one stretch with no idling, one long receiver hold-off
    phase = 0;
    big_done = 1'b0;
    while (element_count < 1550 || !big_done) begin
      if (phase == 3) begin
        raw = 6'd2;
      end else if (phase == 6) begin
        raw = ORDER_REG_BITS'($urandom_range(ORDER_CAP, 63));
        big_done = 1'b1;
      end else begin
        case ($urandom_range(0, 9))
          0: raw = 6'd0;
          1: raw = 6'd1;
          2: raw = ORDER_REG_BITS'($urandom_range(7, 12));
          default: raw = ORDER_REG_BITS'($urandom_range(2, 6));
        endcase
      end
      write_order(raw);
      quiet_stretch = (phase >= 6 && phase < 10);
      n = active_order();
      mats = (n >= 16) ? 1 : $urandom_range(1, 6);
      if (phase == 3) begin
        // keep offering while the receiver holds off
        mats = 12;
        hold_request = 1'b1;
      end
      repeat (mats) stream_matrix(n, n * n);
      // leave a partial matrix for the next order write to drop
      if (n > 1 && $urandom_range(0, 4) == 0) stream_matrix(n, $urandom_range(1, n * n - 1));
      phase++;
    end

    element_valid <= 1'b0;
    while (pending_properties.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("matrix_property_checker_unit_test passed");
    end else begin
      $display("matrix_property_checker_unit_test failed");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure
  initial begin
    #5_000_000;
    $display("matrix_property_checker_unit_test failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/mpc_pkg.sv
rtl/core/mpc_cfg_regs.sv
rtl/core/mpc_store.sv
rtl/core/mpc_accum.sv
rtl/core/matrix_property_checker_unit.sv
tb/matrix_property_checker_unit_test.sv
